FILE: sv/iet_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the ICMP echo tracker.
// No dependencies; used by the tracker, its checksum unit and its checker.
package iet_pkg;

   typedef logic [1:0] status_type;

   localparam status_type ST_BUILT  = 2'd0;
   localparam status_type ST_MATCH  = 2'd1;
   localparam status_type ST_IGNORE = 2'd2;

   localparam logic OP_SEND = 1'b0;
   localparam logic OP_RECV = 1'b1;

   localparam int MAX_CLIENTS_DEF   = 8;
   localparam int PAYLOAD_BYTES_DEF = 32;

   localparam logic [15:0] ID_BASE_RESET     = 16'hA100;
   localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;
   localparam logic [7:0]  ECHO_REPLY_TYPE   = 8'd0;
   localparam logic [15:0] MIN_PACKET_BYTES  = 16'd28;
   localparam logic [15:0] ECHO_HEADER_BYTES = 16'd8;

   // Ones' complement sum of the fixed payload 0,1,2,... as big-endian words.
   // Evaluated at elaboration only.
   function automatic logic [15:0] payload_sum(input int n_bytes);
      logic [31:0] sum;
      logic [31:0] b;
      sum = 32'd0;
      for (int i = 0; i < n_bytes; i++) begin
         b = 32'(i) & 32'h0000_00FF;
         sum = sum + (((i % 2) == 0) ? (b << 8) : b);
         sum = (sum & 32'h0000_FFFF) + (sum >> 16);
      end
      return sum[15:0];
   endfunction

endpackage

FILE: sv/iet_csum.sv
`timescale 1ns / 1ps
// Internet checksum of an outgoing echo request with the fixed payload.
// Depends on iet_pkg for the request type and the payload sum.
module iet_csum #(
   parameter int PAYLOAD_BYTES = iet_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic [15:0] ident,
   input  logic [15:0] sequence_num,
   output logic [15:0] checksum
);

   localparam logic [15:0] PAY_SUM = iet_pkg::payload_sum(PAYLOAD_BYTES);
   localparam logic [15:0] TYPE_WORD = {iet_pkg::ECHO_REQUEST_TYPE, 8'd0};

   logic [17:0] total;
   logic [16:0] fold1;
   logic [15:0] fold2;

   always_comb begin
      total = 18'(TYPE_WORD) + 18'(ident) + 18'(sequence_num) + 18'(PAY_SUM);
      // two end-around carries bring the sum back to 16 bits
      fold1 = 17'(total[15:0]) + 17'(total[17:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
      checksum = ~fold2;
   end

endmodule

FILE: sv/icmp_echo_tracker.sv
`timescale 1ns / 1ps
// ICMP echo tracker: builds echo requests per client and matches echo replies.
// One transaction is accepted per cycle while the result side keeps up. The
// accepting edge reads the client's sequence number from a memory with a
// registered read port; the edge on which the transaction completes writes it
// back and loads the result register; a request to the same client accepted
// at that edge gets the written value forwarded. Active and reply
// flags sit in flip-flops and are cleared by reset, so no clearing pass is
// needed. id_base may be written only while no transaction is in flight.
// Depends on iet_pkg and iet_csum.
module icmp_echo_tracker #(
   parameter int MAX_CLIENTS   = iet_pkg::MAX_CLIENTS_DEF,
   parameter int PAYLOAD_BYTES = iet_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [2:0]  req_client,
   input  logic [31:0] req_dest_ip,
   input  logic [15:0] req_total_length,
   input  logic [3:0]  req_header_words,
   input  logic [7:0]  req_icmp_type,
   input  logic [15:0] req_icmp_ident,
   input  logic [15:0] req_icmp_sequence,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_echo_ident,
   output logic [15:0] rsp_echo_sequence,
   output logic [15:0] rsp_echo_checksum,
   output logic [31:0] rsp_out_dest_ip,
   output logic [2:0]  rsp_matched_client
);

   localparam int          IDX_W      = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam logic [15:0] CLIENTS_16 = 16'(MAX_CLIENTS);

   // configuration
   logic [15:0] id_base_ff;

   // lookup stage
   logic             busy_ff;
   logic             op_ff;
   logic             ok_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0]      dest_ff;
   logic [15:0]      rx_seq_ff;
   logic [15:0]      rd_seq_ff;

   // state
   logic [15:0]            seq_mem [MAX_CLIENTS];
   logic [MAX_CLIENTS-1:0] active_ff;
   logic [MAX_CLIENTS-1:0] reply_ff;

   // result register
   logic                     rsp_valid_ff;
   iet_pkg::status_type      status_ff;
   logic [15:0]              ident_ff;
   logic [15:0]              sequence_ff;
   logic [15:0]              checksum_ff;
   logic [31:0]              out_dest_ff;
   logic [2:0]               matched_ff;

   // accept side
   logic             accept;
   logic [15:0]      diff;
   logic [15:0]      client16;
   logic [15:0]      hdr_len;
   logic             recv_ok;
   logic             send_ok;
   logic [IDX_W-1:0] rd_addr;

   // complete side
   logic        fire;
   logic        hit;
   logic [15:0] seq_cur;
   logic [15:0] nseq;
   logic [15:0] eid;
   logic [15:0] chk;
   logic        build;
   logic        match;
   logic        wr_en;
   logic        fwd;
   logic [7:0]  idx8;

   always_comb begin
      fire     = busy_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = busy_ff && !fire;
      accept   = req_valid && !req_stall;

      diff     = req_icmp_ident - id_base_ff;
      client16 = {13'd0, req_client};
      hdr_len  = {10'd0, req_header_words, 2'b00} + iet_pkg::ECHO_HEADER_BYTES;
      recv_ok  = (req_total_length >= iet_pkg::MIN_PACKET_BYTES)
              && (req_total_length >= hdr_len)
              && (req_icmp_type == iet_pkg::ECHO_REPLY_TYPE)
              && (req_icmp_ident >= id_base_ff)
              && (diff < CLIENTS_16);
      send_ok  = client16 < CLIENTS_16;
      rd_addr  = (req_opcode == iet_pkg::OP_SEND) ? client16[IDX_W-1:0] : diff[IDX_W-1:0];

      // an entry never sent to reads as zero
      hit     = ok_ff && active_ff[idx_ff];
      seq_cur = hit ? rd_seq_ff : 16'd0;
      nseq    = seq_cur + 16'd1;
      eid     = id_base_ff + 16'(idx_ff);
      build   = (op_ff == iet_pkg::OP_SEND) && ok_ff;
      match   = (op_ff == iet_pkg::OP_RECV) && hit && (rx_seq_ff == rd_seq_ff);
      wr_en   = fire && build;
      fwd     = wr_en && (rd_addr == idx_ff);
      idx8    = 8'(idx_ff);
   end

   iet_csum #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_csum (
      .ident       (eid),
      .sequence_num(nseq),
      .checksum    (chk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff <= iet_pkg::ID_BASE_RESET;
      end else if (csr_write_enable) begin
         id_base_ff <= csr_write_data;
      end
   end

   // sequence memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem[idx_ff] <= nseq;
      end
      if (accept) begin
         // forward the write-back to a transaction on the same client
         rd_seq_ff <= fwd ? nseq : seq_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         reply_ff     <= '0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (fire) begin
            busy_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            active_ff[idx_ff] <= 1'b1;
         end
         if (fire && match) begin
            reply_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_opcode;
         ok_ff     <= (req_opcode == iet_pkg::OP_SEND) ? send_ok : recv_ok;
         idx_ff    <= rd_addr;
         dest_ff   <= req_dest_ip;
         rx_seq_ff <= req_icmp_sequence;
      end
      if (fire) begin
         if (build) begin
            status_ff <= iet_pkg::ST_BUILT;
         end else if (match) begin
            status_ff <= iet_pkg::ST_MATCH;
         end else begin
            status_ff <= iet_pkg::ST_IGNORE;
         end
         ident_ff    <= build ? eid : 16'd0;
         sequence_ff <= build ? nseq : 16'd0;
         checksum_ff <= build ? chk : 16'd0;
         out_dest_ff <= build ? dest_ff : 32'd0;
         matched_ff  <= match ? idx8[2:0] : 3'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_echo_ident     = ident_ff;
   assign rsp_echo_sequence  = sequence_ff;
   assign rsp_echo_checksum  = checksum_ff;
   assign rsp_out_dest_ip    = out_dest_ff;
   assign rsp_matched_client = matched_ff;

endmodule

FILE: sv/iet_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ICMP echo tracker, bound to the top level.
// Depends on iet_pkg for the status codes.
module iet_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_write_enable,
   input logic [15:0] csr_write_data,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_opcode,
   input logic [2:0]  req_client,
   input logic [31:0] req_dest_ip,
   input logic [15:0] req_total_length,
   input logic [3:0]  req_header_words,
   input logic [7:0]  req_icmp_type,
   input logic [15:0] req_icmp_ident,
   input logic [15:0] req_icmp_sequence,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_echo_ident,
   input logic [15:0] rsp_echo_sequence,
   input logic [15:0] rsp_echo_checksum,
   input logic [31:0] rsp_out_dest_ip,
   input logic [2:0]  rsp_matched_client
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_echo_sequence) && $stable(rsp_matched_client))
      else $error("stalled result changed");

   // a valid result follows every accepted transaction
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("result missing after accepted transaction");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == iet_pkg::ST_BUILT || rsp_status == iet_pkg::ST_MATCH
         || rsp_status == iet_pkg::ST_IGNORE)
      else $error("undefined status code");

   a_request_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != iet_pkg::ST_BUILT |-> rsp_echo_ident == 16'd0
         && rsp_echo_sequence == 16'd0 && rsp_echo_checksum == 16'd0
         && rsp_out_dest_ip == 32'd0)
      else $error("request fields set without a built request");

   a_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != iet_pkg::ST_MATCH |-> rsp_matched_client == 3'd0)
      else $error("matched client set without a match");

endmodule

bind icmp_echo_tracker iet_checker u_iet_checker (.*);
